>>> hw/rtl/frgf_pkg.sv
// Shared types and register map of the free run gap finder.
package frgf_pkg;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_START_CLUSTER   = 3'd0;
  localparam logic [IDX_W-1:0] REG_STOP_CLUSTER    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_GAP_SIZE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_STRICT_FIT      = 3'd3;
  localparam logic [IDX_W-1:0] REG_FIND_HIGHEST    = 3'd4;
  localparam logic [IDX_W-1:0] REG_IGNORE_EXCLUDES = 3'd5;

  typedef struct packed {
    logic strict_fit;
    logic find_highest;
    logic ignore_excludes;
  } cfg_flags_t;

  typedef struct packed {
    logic used;
    logic excluded;
    logic last;
  } item_t;

endpackage

>>> hw/rtl/frgf_cfg.sv
// Configuration register file with APB-style access.
module frgf_cfg #(
  parameter int CLUSTER_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frgf_pkg::ADDR_W-1:0]   paddr,
  input  logic [frgf_pkg::DATA_W-1:0]   pwdata,
  output logic [frgf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [CLUSTER_BITS-1:0]       start_cluster,
  output logic [CLUSTER_BITS-1:0]       stop_cluster,
  output logic [CLUSTER_BITS-1:0]       min_gap_size,
  output frgf_pkg::cfg_flags_t          flags
);

  logic [CLUSTER_BITS-1:0]   start_r, stop_r, min_r;
  frgf_pkg::cfg_flags_t      flags_r;
  logic [frgf_pkg::IDX_W-1:0] idx;
  logic                      wr_en;

  assign idx    = paddr[frgf_pkg::ADDR_W-1:frgf_pkg::ADDR_W-frgf_pkg::IDX_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      stop_r  <= '1;
      min_r   <= CLUSTER_BITS'(1);
      flags_r <= '{strict_fit: 1'b1, find_highest: 1'b0, ignore_excludes: 1'b0};
    end else if (wr_en) begin
      unique case (idx)
        frgf_pkg::REG_START_CLUSTER:   start_r <= pwdata[CLUSTER_BITS-1:0];
        frgf_pkg::REG_STOP_CLUSTER:    stop_r  <= pwdata[CLUSTER_BITS-1:0];
        frgf_pkg::REG_MIN_GAP_SIZE:    min_r   <= pwdata[CLUSTER_BITS-1:0];
        frgf_pkg::REG_STRICT_FIT:      flags_r.strict_fit      <= pwdata[0];
        frgf_pkg::REG_FIND_HIGHEST:    flags_r.find_highest    <= pwdata[0];
        frgf_pkg::REG_IGNORE_EXCLUDES: flags_r.ignore_excludes <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      frgf_pkg::REG_START_CLUSTER:   prdata = frgf_pkg::DATA_W'(start_r);
      frgf_pkg::REG_STOP_CLUSTER:    prdata = frgf_pkg::DATA_W'(stop_r);
      frgf_pkg::REG_MIN_GAP_SIZE:    prdata = frgf_pkg::DATA_W'(min_r);
      frgf_pkg::REG_STRICT_FIT:      prdata = frgf_pkg::DATA_W'(flags_r.strict_fit);
      frgf_pkg::REG_FIND_HIGHEST:    prdata = frgf_pkg::DATA_W'(flags_r.find_highest);
      frgf_pkg::REG_IGNORE_EXCLUDES: prdata = frgf_pkg::DATA_W'(flags_r.ignore_excludes);
      default:                       prdata = '0;
    endcase
  end

  assign start_cluster = start_r;
  assign stop_cluster  = stop_r;
  assign min_gap_size  = min_r;
  assign flags         = flags_r;

endmodule

>>> hw/rtl/frgf_core.sv
// Scan state and per-cluster run tracking; decides each item's result.
module frgf_core #(
  parameter int CLUSTER_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CLUSTER_BITS-1:0] start_cluster,
  input  logic [CLUSTER_BITS-1:0] stop_cluster,
  input  logic [CLUSTER_BITS-1:0] min_gap_size,
  input  frgf_pkg::cfg_flags_t    flags,
  input  frgf_pkg::item_t         item,
  input  logic                    take,
  output logic                    emit,
  output logic                    res_found,
  output logic [CLUSTER_BITS-1:0] res_begin,
  output logic [CLUSTER_BITS-1:0] res_end
);

  localparam int CB = CLUSTER_BITS;

  logic          active_r, prev_r, done_r;
  logic [CB-1:0] pos_r, rs_r, hb_r, he_r, lb_r, le_r;

  logic          active_nxt, prev_nxt, done_nxt;
  logic [CB-1:0] pos_nxt, rs_nxt, hb_nxt, he_nxt, lb_nxt, le_nxt;

  logic          c_prev, c_done;
  logic [CB-1:0] c_pos, c_rs, c_hb, c_he, c_lb, c_le;
  logic          used, in_range, closing, scan_end, do_close, qual, ff_hit;
  logic [CB:0]   pos_p1;
  logic [CB-1:0] run_rs, cl_rs, cl_lim, len, upd_hb, upd_he, upd_lb, upd_le;

  always_comb begin
    // an item with no scan running starts one
    c_prev = active_r ? prev_r : 1'b1;
    c_done = active_r ? done_r : 1'b0;
    c_pos  = active_r ? pos_r  : start_cluster;
    c_rs   = active_r ? rs_r   : '0;
    c_hb   = active_r ? hb_r   : '0;
    c_he   = active_r ? he_r   : '0;
    c_lb   = active_r ? lb_r   : '0;
    c_le   = active_r ? le_r   : '0;

    used     = item.used || (item.excluded && !flags.ignore_excludes);
    in_range = c_pos < stop_cluster;
    pos_p1   = {1'b0, c_pos} + (CB+1)'(1);
    closing  = in_range && !c_prev && used;
    run_rs   = (in_range && c_prev && !used) ? c_pos : c_rs;
    scan_end = !in_range || item.last || (pos_p1 >= {1'b0, stop_cluster});

    // at most one run closes per item: on a used cluster, or at scan end
    if (closing) begin
      do_close = 1'b1;
      cl_rs    = c_rs;
      cl_lim   = c_pos;
    end else begin
      do_close = scan_end && (in_range ? !used : !c_prev);
      cl_rs    = run_rs;
      cl_lim   = in_range ? pos_p1[CB-1:0] : c_pos;
    end

    len    = cl_lim - cl_rs;
    qual   = do_close && (cl_rs >= start_cluster) && (len >= min_gap_size);
    ff_hit = qual && !flags.find_highest;

    upd_hb = (qual && flags.find_highest) ? cl_rs  : c_hb;
    upd_he = (qual && flags.find_highest) ? cl_lim : c_he;
    if (do_close && ((c_lb == '0) || ((c_le - c_lb) < len))) begin
      upd_lb = cl_rs;
      upd_le = cl_lim;
    end else begin
      upd_lb = c_lb;
      upd_le = c_le;
    end

    active_nxt = 1'b1;
    prev_nxt   = c_prev;
    done_nxt   = c_done;
    pos_nxt    = c_pos;
    rs_nxt     = c_rs;
    hb_nxt     = c_hb;
    he_nxt     = c_he;
    lb_nxt     = c_lb;
    le_nxt     = c_le;
    emit       = 1'b0;
    res_found  = 1'b0;
    res_begin  = '0;
    res_end    = '0;

    priority if (c_done) begin
      // first fit already answered: drop items until the volume end
      active_nxt = !item.last;
    end else if (ff_hit) begin
      emit       = 1'b1;
      res_found  = 1'b1;
      res_begin  = cl_rs;
      res_end    = cl_lim;
      done_nxt   = 1'b1;
      active_nxt = closing ? !item.last : 1'b0;
      pos_nxt    = pos_p1[CB-1:0];
    end else begin
      prev_nxt = in_range ? used : c_prev;
      rs_nxt   = run_rs;
      hb_nxt   = upd_hb;
      he_nxt   = upd_he;
      lb_nxt   = upd_lb;
      le_nxt   = upd_le;
      if (scan_end) begin
        active_nxt = 1'b0;
        emit       = 1'b1;
        priority if (flags.find_highest && (upd_hb != '0)) begin
          res_found = 1'b1;
          res_begin = upd_hb;
          res_end   = upd_he;
        end else if (!flags.strict_fit && (upd_lb != '0)) begin
          res_found = 1'b1;
          res_begin = upd_lb;
          res_end   = upd_le;
        end else begin
          res_found = 1'b0;
        end
      end else begin
        pos_nxt = pos_p1[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      prev_r   <= 1'b1;
      done_r   <= 1'b0;
    end else if (take) begin
      active_r <= active_nxt;
      prev_r   <= prev_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pos_r <= pos_nxt;
      rs_r  <= rs_nxt;
      hb_r  <= hb_nxt;
      he_r  <= he_nxt;
      lb_r  <= lb_nxt;
      le_r  <= le_nxt;
    end
  end

endmodule

>>> hw/rtl/frgf_out_reg.sv
// Result register that holds a finished item until the sink takes it.
module frgf_out_reg #(
  parameter int CLUSTER_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic                    res_found,
  input  logic [CLUSTER_BITS-1:0] res_begin,
  input  logic [CLUSTER_BITS-1:0] res_end,
  output logic                    free,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_gap_found,
  output logic [CLUSTER_BITS-1:0] out_gap_begin,
  output logic [CLUSTER_BITS-1:0] out_gap_end
);

  logic                    valid_r, valid_nxt;
  logic                    found_r;
  logic [CLUSTER_BITS-1:0] begin_r, end_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found_r <= res_found;
      begin_r <= res_begin;
      end_r   <= res_end;
    end
  end

  assign out_valid     = valid_r;
  assign out_gap_found = found_r;
  assign out_gap_begin = begin_r;
  assign out_gap_end   = end_r;

endmodule

>>> hw/rtl/free_run_gap_finder.sv
// Free run gap finder: scans an allocation bitmap one cluster per item.
// A result passes through the item register and then the output register; an item can wait in the item register.
// Throughput: one item per cycle unless its result is due while a stalled result holds the output register.
// An item that yields no result moves on even while a result waits in the output register.
// Reset (rst_n low, synchronous) empties both stages, ends any scan and loads
// the register defaults.
module free_run_gap_finder #(
  parameter int CLUSTER_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cluster_used,
  input  logic                          in_cluster_excluded,
  input  logic                          in_volume_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_gap_found,
  output logic [CLUSTER_BITS-1:0]       out_gap_begin,
  output logic [CLUSTER_BITS-1:0]       out_gap_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frgf_pkg::ADDR_W-1:0]   paddr,
  input  logic [frgf_pkg::DATA_W-1:0]   pwdata,
  output logic [frgf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [CLUSTER_BITS-1:0] start_cluster, stop_cluster, min_gap_size;
  frgf_pkg::cfg_flags_t    flags;

  logic                    item_v_r, item_v_nxt;
  frgf_pkg::item_t         item_r;
  logic                    in_acc, take, emit, out_free;
  logic                    res_found;
  logic [CLUSTER_BITS-1:0] res_begin, res_end;

  frgf_cfg #(.CLUSTER_BITS(CLUSTER_BITS)) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start_cluster (start_cluster),
    .stop_cluster  (stop_cluster),
    .min_gap_size  (min_gap_size),
    .flags         (flags)
  );

  // advance the held item unless its result has nowhere to go
  assign take       = item_v_r && (!emit || out_free);
  assign in_stall   = item_v_r && !take;
  assign in_acc     = in_valid && !in_stall;
  assign item_v_nxt = in_acc ? 1'b1 : (item_v_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= '{used: in_cluster_used, excluded: in_cluster_excluded, last: in_volume_end};
    end
  end

  frgf_core #(.CLUSTER_BITS(CLUSTER_BITS)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_cluster (start_cluster),
    .stop_cluster  (stop_cluster),
    .min_gap_size  (min_gap_size),
    .flags         (flags),
    .item          (item_r),
    .take          (take),
    .emit          (emit),
    .res_found     (res_found),
    .res_begin     (res_begin),
    .res_end       (res_end)
  );

  frgf_out_reg #(.CLUSTER_BITS(CLUSTER_BITS)) u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (take && emit),
    .res_found     (res_found),
    .res_begin     (res_begin),
    .res_end       (res_end),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_gap_found (out_gap_found),
    .out_gap_begin (out_gap_begin),
    .out_gap_end   (out_gap_end)
  );

endmodule

>>> hw/rtl/frgf_chk.sv
// Port-level assertions for the free run gap finder, bound to the top level.
module frgf_chk #(
  parameter int CLUSTER_BITS = 48
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_gap_found,
  input logic [CLUSTER_BITS-1:0] out_gap_begin,
  input logic [CLUSTER_BITS-1:0] out_gap_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gap_found)
      && $stable(out_gap_begin) && $stable(out_gap_end))
    else $error("stalled result changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_gap_found |-> (out_gap_begin == '0) && (out_gap_end == '0))
    else $error("not-found result carries a gap");

  // a first-fit answer may start at cluster zero, so only the order is checked
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gap_found |-> (out_gap_end > out_gap_begin))
    else $error("returned gap is empty");

  // an item passes through the item register and the output register before it reaches the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid)
    else $error("result shown too soon after reset");

  // with no item in flight the input side never stalls
  a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_valid ##1 !in_valid |-> !in_stall)
    else $error("input stalled with nothing in flight");

endmodule

bind free_run_gap_finder frgf_chk #(.CLUSTER_BITS(CLUSTER_BITS)) u_frgf_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_gap_found (out_gap_found),
  .out_gap_begin (out_gap_begin),
  .out_gap_end   (out_gap_end)
);

>>> bench/free_run_gap_finder_tb.sv
// Self-checking testbench for the free run gap finder: bitmap scans against a cycle-free predictor.
`timescale 1ns / 100ps
module free_run_gap_finder_tb;

  localparam int CB = 48;
  localparam logic [CB-1:0] CLUSTER_MAX = '1;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEM_TARGET = 1650;

  typedef struct {
    bit            found;
    logic [CB-1:0] lo;
    logic [CB-1:0] hi;
  } gap_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_cluster_used = 1'b0;
  logic                        in_cluster_excluded = 1'b0;
  logic                        in_volume_end = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_gap_found;
  logic [CB-1:0]               out_gap_begin;
  logic [CB-1:0]               out_gap_end;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [frgf_pkg::ADDR_W-1:0] paddr = '0;
  logic [frgf_pkg::DATA_W-1:0] pwdata = '0;
  logic [frgf_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  free_run_gap_finder #(.CLUSTER_BITS(CB)) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cluster_used     (in_cluster_used),
    .in_cluster_excluded (in_cluster_excluded),
    .in_volume_end       (in_volume_end),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_gap_found       (out_gap_found),
    .out_gap_begin       (out_gap_begin),
    .out_gap_end         (out_gap_end),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the registers and of the scan state.
  logic [CB-1:0] cfg_start, cfg_stop, cfg_min;
  bit            cfg_strict_fit, cfg_find_highest, cfg_ignore_excl;
  bit            scan_on, prev_used, answered;
  logic [CB-1:0] pos, run_lo, high_lo, high_hi, big_lo, big_hi;

  gap_t            expected_gaps[$];
  frgf_pkg::item_t pending_items[$];
  frgf_pkg::item_t next_item, seen_item;
  int    items_queued = 0;
  int    items_taken = 0;
  int    mismatches = 0;
  int    quiet = 0;
  int    send_gap = 0;
  int    stall_left = 0;
  bit    item_taken = 1'b0;
  bit    gap_taken = 1'b0;
  bit    idle_on = 1'b1;

  function automatic void begin_scan();
    scan_on   = 1'b1;
    pos       = cfg_start;
    prev_used = 1'b1;
    run_lo    = '0;
    high_lo   = '0;
    high_hi   = '0;
    big_lo    = '0;
    big_hi    = '0;
    answered  = 1'b0;
  endfunction

  // Judge the free run ending just before cluster lim; 1 means first-fit answers now.
  function automatic bit close_free_run(logic [CB-1:0] lim);
    logic [CB-1:0] len;
    len = lim - run_lo;
    if (run_lo >= cfg_start && len >= cfg_min) begin
      if (!cfg_find_highest) return 1'b1;
      high_lo = run_lo;
      high_hi = lim;
    end
    if (big_lo == '0 || big_hi - big_lo < len) begin
      big_lo = run_lo;
      big_hi = lim;
    end
    return 1'b0;
  endfunction

  function automatic void predict_cluster(frgf_pkg::item_t it);
    bit            used_now, fin;
    logic [CB-1:0] lim;
    used_now = it.used || (it.excluded && !cfg_ignore_excl);
    if (!scan_on) begin_scan();
    // after a first-fit answer, drop items until the volume end
    if (answered) begin
      if (it.last) scan_on = 1'b0;
      return;
    end
    if (pos < cfg_stop) begin
      if (!prev_used && used_now && close_free_run(pos)) begin
        expected_gaps.push_back('{1'b1, run_lo, pos});
        answered = 1'b1;
        if (it.last) scan_on = 1'b0;
        else pos = pos + CB'(1);
        return;
      end
      if (prev_used && !used_now) run_lo = pos;
      prev_used = used_now;
      fin = it.last || ({1'b0, pos} + (CB+1)'(1) >= {1'b0, cfg_stop});
      lim = pos + CB'(1);
    end else begin
      fin = 1'b1;
      lim = pos;
    end
    if (!fin) begin
      pos = pos + CB'(1);
      return;
    end
    scan_on = 1'b0;
    if (!prev_used && close_free_run(lim)) expected_gaps.push_back('{1'b1, run_lo, lim});
    else if (cfg_find_highest && high_lo != '0) expected_gaps.push_back('{1'b1, high_lo, high_hi});
    else if (!cfg_strict_fit && big_lo != '0) expected_gaps.push_back('{1'b1, big_lo, big_hi});
    else expected_gaps.push_back('{1'b0, '0, '0});
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid            <= 1'b0;
        in_cluster_used     <= 1'($urandom_range(0, 1));
        in_cluster_excluded <= 1'($urandom_range(0, 1));
        in_volume_end       <= 1'($urandom_range(0, 1));
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_valid            <= 1'b1;
        in_cluster_used     <= next_item.used;
        in_cluster_excluded <= next_item.excluded;
        in_volume_end       <= next_item.last;
        send_gap = gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = gap_len();
    end
  end

  // Monitor: check results against the oldest expectation, predict accepted items
  always @(posedge clk) begin
    gap_t want;
    if (rst_n) begin
      item_taken = in_valid && !in_stall;
      gap_taken  = out_valid && !out_stall;
      if (gap_taken) begin
        if (expected_gaps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found=%0d begin=%h end=%h",
                     out_gap_found, out_gap_begin, out_gap_end);
        end else begin
          want = expected_gaps.pop_front();
          if (want.found !== out_gap_found || want.lo !== out_gap_begin ||
              want.hi !== out_gap_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected found=%0d begin=%h end=%h, ",
                        "got found=%0d begin=%h end=%h"},
                       want.found, want.lo, want.hi, out_gap_found, out_gap_begin, out_gap_end);
          end
        end
      end
      if (item_taken) begin
        seen_item = '{used: in_cluster_used, excluded: in_cluster_excluded, last: in_volume_end};
        predict_cluster(seen_item);
        items_taken++;
      end
      quiet = (item_taken || gap_taken) ? 0 : quiet + 1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic push_item(bit u, bit e, bit l);
    pending_items.push_back('{used: u, excluded: e, last: l});
    items_queued++;
  endtask

  task automatic push_bits(int n, logic [31:0] used_bits, logic [31:0] excl_bits, bit close);
    for (int i = 0; i < n; i++)
      push_item(used_bits[i], excl_bits[i], close && i == n - 1);
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || expected_gaps.size() != 0) @(negedge clk);
    // let any silent item finish inside the block
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [frgf_pkg::IDX_W-1:0] idx, logic [CB-1:0] v);
    logic [frgf_pkg::DATA_W-1:0] wdata;
    wdata = {$urandom, $urandom};
    if (idx == frgf_pkg::REG_STRICT_FIT || idx == frgf_pkg::REG_FIND_HIGHEST ||
        idx == frgf_pkg::REG_IGNORE_EXCLUDES)
      wdata[0] = v[0];
    else
      wdata[CB-1:0] = v;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      frgf_pkg::REG_START_CLUSTER:   cfg_start        = wdata[CB-1:0];
      frgf_pkg::REG_STOP_CLUSTER:    cfg_stop         = wdata[CB-1:0];
      frgf_pkg::REG_MIN_GAP_SIZE:    cfg_min          = wdata[CB-1:0];
      frgf_pkg::REG_STRICT_FIT:      cfg_strict_fit   = wdata[0];
      frgf_pkg::REG_FIND_HIGHEST:    cfg_find_highest = wdata[0];
      frgf_pkg::REG_IGNORE_EXCLUDES: cfg_ignore_excl  = wdata[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_cfg(logic [CB-1:0] st, logic [CB-1:0] sp, logic [CB-1:0] mn,
                         bit mf, bit fh, bit ie);
    wait_drained();
    write_reg(frgf_pkg::REG_START_CLUSTER, st);
    write_reg(frgf_pkg::REG_STOP_CLUSTER, sp);
    write_reg(frgf_pkg::REG_MIN_GAP_SIZE, mn);
    write_reg(frgf_pkg::REG_STRICT_FIT, CB'(mf));
    write_reg(frgf_pkg::REG_FIND_HIGHEST, CB'(fh));
    write_reg(frgf_pkg::REG_IGNORE_EXCLUDES, CB'(ie));
  endtask

  // Bitmap with alternating used and free runs, a little noise and a few early volume ends
  task automatic random_scan(int n);
    int left;
    bit free_now, u, e, l;
    left = 0;
    free_now = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        free_now = !free_now;
        left = free_now ? $urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 6)
                        : $urandom_range(1, 4);
      end
      left--;
      u = !free_now;
      if ($urandom_range(0, 29) == 0) u = !u;
      e = ($urandom_range(0, 7) == 0);
      l = (i == n - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0);
      push_item(u, e, l);
    end
  endtask

  initial begin
    logic [CB-1:0] st, sp, mn;
    cfg_start        = '0;
    cfg_stop         = CLUSTER_MAX;
    cfg_min          = CB'(1);
    cfg_strict_fit   = 1'b1;
    cfg_find_highest = 1'b0;
    cfg_ignore_excl  = 1'b0;
    begin_scan();
    scan_on = 1'b0;
    pos     = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: first fit returns the run at cluster 0, rest ignored
    push_bits(5, 32'b10100, 32'b0, 1'b1);
    // highest qualifying run, excluded cluster counts as used, scan ends at stop
    set_cfg(CB'(4), CB'(12), CB'(2), 1'b0, 1'b1, 1'b0);
    push_bits(8, 32'b01000100, 32'b00001000, 1'b0);
    // empty scan
    set_cfg(CB'(20), CB'(20), CB'(1), 1'b0, 1'b0, 1'b1);
    push_bits(1, 32'b0, 32'b0, 1'b0);
    // top of the cluster range, nothing qualifies, fall back to the largest run
    set_cfg(CLUSTER_MAX - CB'(5), CLUSTER_MAX, CLUSTER_MAX, 1'b0, 1'b1, 1'b1);
    push_bits(5, 32'b0, 32'b11111, 1'b0);
    // run at cluster 0 counts as none
    set_cfg('0, CLUSTER_MAX, '0, 1'b0, 1'b1, 1'b0);
    push_bits(3, 32'b110, 32'b0, 1'b1);

    while (items_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       st = '0;
        1:       st = CB'($urandom_range(1, 40));
        2:       st = CLUSTER_MAX - CB'($urandom_range(0, 100));
        default: st = CB'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2, 3: sp = (st > CLUSTER_MAX - CB'(64)) ? CLUSTER_MAX
                                                      : st + CB'($urandom_range(1, 60));
        4:          sp = CLUSTER_MAX;
        5:          sp = (st >= CB'(3)) ? st - CB'($urandom_range(0, 3)) : '0;
        6:          sp = CB'({$urandom, $urandom});
        default:    sp = '0;
      endcase
      case ($urandom_range(0, 5))
        0:       mn = '0;
        1:       mn = CB'(1);
        2, 3:    mn = CB'($urandom_range(2, 8));
        4:       mn = CLUSTER_MAX;
        default: mn = CB'({$urandom, $urandom});
      endcase
      set_cfg(st, sp, mn, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 6)) random_scan($urandom_range(1, 40));
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
